// ===== hdl/tc16_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tc16_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ADDR_CTRL_A  = 4'd0,
      ADDR_CTRL_B  = 4'd1,
      ADDR_CTRL_C  = 4'd2,
      ADDR_UNUSED  = 4'd3,
      ADDR_CNT_LO  = 4'd4,
      ADDR_CNT_HI  = 4'd5,
      ADDR_ICR_LO  = 4'd6,
      ADDR_ICR_HI  = 4'd7,
      ADDR_OCRA_LO = 4'd8,
      ADDR_OCRA_HI = 4'd9,
      ADDR_OCRB_LO = 4'd10,
      ADDR_OCRB_HI = 4'd11,
      ADDR_OCRC_LO = 4'd12,
      ADDR_OCRC_HI = 4'd13,
      ADDR_MASK    = 4'd14,
      ADDR_FLAGS   = 4'd15
   } addr_type;

   typedef enum logic [2:0] {
      CS_STOP    = 3'd0,
      CS_DIV1    = 3'd1,
      CS_DIV8    = 3'd2,
      CS_DIV64   = 3'd3,
      CS_DIV256  = 3'd4,
      CS_DIV1024 = 3'd5,
      CS_EXT_FALL = 3'd6,
      CS_EXT_RISE = 3'd7
   } clk_sel_type;

   localparam logic [3:0] MODE_CTC_A   = 4'd4;
   localparam logic [3:0] MODE_CTC_ICR = 4'd12;

   localparam logic [7:0] INT_TOV = 8'h01;
   localparam logic [7:0] INT_OCA = 8'h02;
   localparam logic [7:0] INT_OCB = 8'h04;
   localparam logic [7:0] INT_OCC = 8'h08;
   localparam logic [7:0] INT_IC  = 8'h20;

   localparam logic [15:0] COUNT_MAX = 16'hffff;

   typedef struct packed {
      logic [7:0] rdata;
      logic [7:0] irq_pending;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== hdl/timer_counter_16bit_ctc_core.sv =====
// 16-bit timer/counter with prescaler and clear-on-match modes, behind byte registers.
// The req_ channel carries one word per access: req_op selects a CPU clock tick,
// a register read, a register write or a no-op; req_addr and req_wdata give the
// register offset and the byte written. Every accepted word produces exactly one
// rsp_ word with the byte read (zero for anything but a read) and the pending
// interrupts, that is the flag bits masked by the interrupt mask after the access.
// All register and counter updates happen at the edge at which the request is
// accepted; the response is registered in the output register, or in the skid
// entry if it holds a stalled word. It takes one word per cycle while req_stall is low.
// The response side has an output register plus one skid entry, so a request is
// still taken in the cycle the receiver first raises rsp_stall; req_stall rises
// only once both entries hold words, and words leave in order.
// Synchronous reset clears all timer registers, the prescaler, the high-byte
// latch and both response entries; no responses are pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module timer_counter_16bit_ctc_core
   import tc16_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [3:0] req_addr,
   input  wire logic [7:0] req_wdata,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_rdata,
   output logic [7:0]      rsp_irq_pending
);

   logic [7:0]  ctrl_a_ff, ctrl_a_in;
   logic [7:0]  ctrl_b_ff, ctrl_b_in;
   logic [7:0]  ctrl_c_ff, ctrl_c_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  latch_ff, latch_in;
   logic [15:0] icr_ff, icr_in;
   logic [15:0] ocra_ff, ocra_in;
   logic [15:0] ocrb_ff, ocrb_in;
   logic [15:0] ocrc_ff, ocrc_in;
   logic [7:0]  mask_ff, mask_in;
   logic [7:0]  flags_ff, flags_in;
   logic [9:0]  presc_ff, presc_in;

   rsp_word_type out0_ff, out0_in;
   rsp_word_type out1_ff, out1_in;
   logic         valid0_ff, valid0_in;
   logic         valid1_ff, valid1_in;

   logic         req_accept;
   logic         rsp_pop;
   rsp_word_type new_word;
   logic [3:0]   mode;
   logic [2:0]   clk_sel;
   logic         run;
   logic [9:0]   presc_inc;
   logic         presc_edge;
   logic [15:0]  count_step;
   logic [7:0]   rd_byte;

   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = valid0_ff && !rsp_stall;
   assign mode       = {ctrl_b_ff[4:3], ctrl_a_ff[1:0]};
   assign clk_sel    = ctrl_b_ff[2:0];
   assign presc_inc  = presc_ff + 10'd1;

   always_comb begin
      run        = 1'b1;
      presc_edge = 1'b0;
      case (clk_sel_type'(clk_sel))
         CS_DIV1:    presc_edge = 1'b1;
         CS_DIV8:    presc_edge = (presc_inc[2:0] == 3'd0);
         CS_DIV64:   presc_edge = (presc_inc[5:0] == 6'd0);
         CS_DIV256:  presc_edge = (presc_inc[7:0] == 8'd0);
         CS_DIV1024: presc_edge = (presc_inc == 10'd0);
         default:    run = 1'b0;
      endcase
   end

   always_comb begin
      if ((mode == MODE_CTC_A && count_ff == ocra_ff) ||
          (mode == MODE_CTC_ICR && count_ff == icr_ff)) begin
         count_step = 16'd0;
      end else begin
         count_step = count_ff + 16'd1;
      end
   end

   always_comb begin
      ctrl_a_in = ctrl_a_ff;
      ctrl_b_in = ctrl_b_ff;
      ctrl_c_in = ctrl_c_ff;
      count_in  = count_ff;
      latch_in  = latch_ff;
      icr_in    = icr_ff;
      ocra_in   = ocra_ff;
      ocrb_in   = ocrb_ff;
      ocrc_in   = ocrc_ff;
      mask_in   = mask_ff;
      flags_in  = flags_ff;
      presc_in  = presc_ff;
      rd_byte   = 8'd0;
      case (op_type'(req_op))
         OP_TICK: begin
            if (run) begin
               presc_in = presc_inc;
               if (presc_edge) begin
                  count_in = count_step;
                  if (count_ff == COUNT_MAX) begin
                     flags_in = flags_in | (mask_ff & INT_TOV);
                  end
                  if (count_step == ocra_ff) begin
                     flags_in = flags_in | (mask_ff & INT_OCA);
                  end
                  if (count_step == ocrb_ff) begin
                     flags_in = flags_in | (mask_ff & INT_OCB);
                  end
                  if (count_step == ocrc_ff) begin
                     flags_in = flags_in | (mask_ff & INT_OCC);
                  end
                  if (mode == MODE_CTC_ICR && count_step == icr_ff) begin
                     flags_in = flags_in | (mask_ff & INT_IC);
                  end
               end
            end
         end
         OP_READ: begin
            case (addr_type'(req_addr))
               ADDR_CTRL_A:  rd_byte = ctrl_a_ff;
               ADDR_CTRL_B:  rd_byte = ctrl_b_ff;
               ADDR_CTRL_C:  rd_byte = ctrl_c_ff;
               ADDR_CNT_LO: begin
                  rd_byte  = count_ff[7:0];
                  latch_in = count_ff[15:8];
               end
               ADDR_CNT_HI:  rd_byte = latch_ff;
               ADDR_ICR_LO: begin
                  rd_byte  = icr_ff[7:0];
                  latch_in = icr_ff[15:8];
               end
               ADDR_ICR_HI:  rd_byte = latch_ff;
               ADDR_OCRA_LO: rd_byte = ocra_ff[7:0];
               ADDR_OCRA_HI: rd_byte = ocra_ff[15:8];
               ADDR_OCRB_LO: rd_byte = ocrb_ff[7:0];
               ADDR_OCRB_HI: rd_byte = ocrb_ff[15:8];
               ADDR_OCRC_LO: rd_byte = ocrc_ff[7:0];
               ADDR_OCRC_HI: rd_byte = ocrc_ff[15:8];
               ADDR_MASK:    rd_byte = mask_ff;
               ADDR_FLAGS:   rd_byte = flags_ff;
               default:      rd_byte = 8'd0;
            endcase
         end
         OP_WRITE: begin
            case (addr_type'(req_addr))
               ADDR_CTRL_A:  ctrl_a_in = req_wdata;
               ADDR_CTRL_B:  ctrl_b_in = req_wdata;
               ADDR_CTRL_C:  ctrl_c_in = req_wdata;
               ADDR_CNT_LO:  count_in = {latch_ff, req_wdata};
               ADDR_CNT_HI:  latch_in = req_wdata;
               ADDR_ICR_LO: begin
                  if (mode == MODE_CTC_ICR) begin
                     icr_in = {latch_ff, req_wdata};
                  end
               end
               ADDR_ICR_HI: begin
                  if (mode == MODE_CTC_ICR) begin
                     latch_in = req_wdata;
                  end
               end
               ADDR_OCRA_LO: ocra_in[7:0]  = req_wdata;
               ADDR_OCRA_HI: ocra_in[15:8] = req_wdata;
               ADDR_OCRB_LO: ocrb_in[7:0]  = req_wdata;
               ADDR_OCRB_HI: ocrb_in[15:8] = req_wdata;
               ADDR_OCRC_LO: ocrc_in[7:0]  = req_wdata;
               ADDR_OCRC_HI: ocrc_in[15:8] = req_wdata;
               ADDR_MASK:    mask_in  = req_wdata;
               ADDR_FLAGS:   flags_in = req_wdata;
               default:      ;
            endcase
         end
         default: ;
      endcase
   end

   assign new_word.rdata       = rd_byte;
   assign new_word.irq_pending = flags_in & mask_in;

   always_comb begin
      out0_in   = out0_ff;
      out1_in   = out1_ff;
      valid0_in = valid0_ff;
      valid1_in = valid1_ff;
      if (rsp_pop) begin
         out0_in   = valid1_ff ? out1_ff : new_word;
         valid0_in = valid1_ff || req_accept;
         valid1_in = 1'b0;
      end else if (!valid0_ff) begin
         out0_in   = new_word;
         valid0_in = req_accept;
      end else if (req_accept) begin
         out1_in   = new_word;
         valid1_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= 8'd0;
         ctrl_b_ff <= 8'd0;
         ctrl_c_ff <= 8'd0;
         count_ff  <= 16'd0;
         latch_ff  <= 8'd0;
         icr_ff    <= 16'd0;
         ocra_ff   <= 16'd0;
         ocrb_ff   <= 16'd0;
         ocrc_ff   <= 16'd0;
         mask_ff   <= 8'd0;
         flags_ff  <= 8'd0;
         presc_ff  <= 10'd0;
      end else if (req_accept) begin
         ctrl_a_ff <= ctrl_a_in;
         ctrl_b_ff <= ctrl_b_in;
         ctrl_c_ff <= ctrl_c_in;
         count_ff  <= count_in;
         latch_ff  <= latch_in;
         icr_ff    <= icr_in;
         ocra_ff   <= ocra_in;
         ocrb_ff   <= ocrb_in;
         ocrc_ff   <= ocrc_in;
         mask_ff   <= mask_in;
         flags_ff  <= flags_in;
         presc_ff  <= presc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else begin
         valid0_ff <= valid0_in;
         valid1_ff <= valid1_in;
      end
   end

   always_ff @(posedge clock) begin
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

   assign req_stall       = valid1_ff;
   assign rsp_valid       = valid0_ff;
   assign rsp_rdata       = out0_ff.rdata;
   assign rsp_irq_pending = out0_ff.irq_pending;

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      valid1_ff |-> valid0_ff)
      else $error("Skid entry holds a word while the output register is empty.");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (req_accept && valid0_ff && rsp_stall) |=> valid1_ff)
      else $error("A word accepted under a stalled response was not kept.");

   a_stopped_count_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == OP_TICK && clk_sel == CS_STOP) |=> $stable(count_ff))
      else $error("The count moved while the clock was stopped.");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> (!valid0_ff && !valid1_ff))
      else $error("Responses are pending right after reset.");

endmodule

`default_nettype wire
